// ===== hw/rtl/priority_packet_queue_dispatch_unit_assert.svh =====
// Assertion macros shared by the priority packet queue dispatch unit RTL.
`ifndef PRIORITY_PACKET_QUEUE_DISPATCH_UNIT_ASSERT_SVH
`define PRIORITY_PACKET_QUEUE_DISPATCH_UNIT_ASSERT_SVH

// Condition implies expression in the same cycle.
`define PPQD_ASSERT_SAME(label, clk, rst, cond, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expr)) \
      else $error(msg);

// Condition implies expression in the next cycle.
`define PPQD_ASSERT_NEXT(label, clk, rst, cond, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) \
      else $error(msg);

`endif

// ===== hw/rtl/ppqd_pkg.sv =====
// Package: types and constants of the priority packet queue dispatch unit.
`default_nettype none
package ppqd_pkg;

   localparam int TIME_BITS  = 16;
   localparam int CLK_BITS   = 32;
   localparam int LEVELS     = 4;
   localparam int LVL_BITS   = 2;
   localparam int PRIO_BITS  = 3;
   localparam int ENTRY_BITS = 2 * TIME_BITS;

   localparam logic ACT_INSERT   = 1'b0;
   localparam logic ACT_DISPATCH = 1'b1;

   localparam logic [PRIO_BITS-1:0] PRIO_MIN = 3'd1;
   localparam logic [PRIO_BITS-1:0] PRIO_MAX = 3'd4;

   typedef enum logic [1:0] {
      ST_INSERTED   = 2'd0,
      ST_DISPATCHED = 2'd1,
      ST_FULL       = 2'd2,
      ST_EMPTY      = 2'd3
   } status_type;

   typedef struct packed {
      logic sub;   // a - b instead of a + b
      logic sat;   // clamp to all ones on carry out of an add
   } alu_ctl_type;

endpackage
`default_nettype wire

// ===== hw/rtl/ppqd_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module ppqd_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 256
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

// ===== hw/rtl/ppqd_alu.sv =====
// Shared 32-bit add/subtract unit with optional saturation and carry/borrow flag.
`default_nettype none
module ppqd_alu (
   input  wire ppqd_pkg::alu_ctl_type ctl,
   input  wire logic [31:0]           op_a,
   input  wire logic [31:0]           op_b,
   output logic      [31:0]           result,
   output logic                       flag
);
   import ppqd_pkg::*;

   logic [32:0] full_sum;

   always_comb begin
      if (ctl.sub) begin
         full_sum = {1'b0, op_a} - {1'b0, op_b};
      end else begin
         full_sum = {1'b0, op_a} + {1'b0, op_b};
      end
      flag = full_sum[32];
      if (ctl.sat && !ctl.sub && full_sum[32]) begin
         result = '1;
      end else begin
         result = full_sum[31:0];
      end
   end

endmodule
`default_nettype wire

// ===== hw/rtl/priority_packet_queue_dispatch_unit.sv =====
// Top level: four-level stable priority packet queue with service clock.
//
//  channel | dir | handshake            | payload
//  --------+-----+----------------------+----------------------------------------
//  req_    | in  | req_valid/req_stall  | action, priority, arrival, transmission
//  rsp_    | out | rsp_valid/rsp_stall  | status, packet, start, wait, total, count
//
//  Insert: accept, RAM write, then result load.
//  Dispatch: one RAM read, then the shared adder runs the wait difference (twice
//  when the clock is behind arrival), total and clock steps.
//  Packets sit in one RAM split into four per-level rings; no clearing after reset.
//  A new request is taken while the previous response still waits on rsp_stall.
`default_nettype none
`include "priority_packet_queue_dispatch_unit_assert.svh"
module priority_packet_queue_dispatch_unit #(
   parameter int QUEUE_DEPTH = 64
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_valid,
   output logic                                     req_stall,
   input  wire logic                                req_action,
   input  wire logic [2:0]                          req_priority_req,
   input  wire logic [15:0]                         req_arrival_time,
   input  wire logic [15:0]                         req_transmission_time,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_stall,
   output ppqd_pkg::status_type                     rsp_status,
   output logic      [2:0]                          rsp_out_priority,
   output logic      [15:0]                         rsp_out_arrival,
   output logic      [15:0]                         rsp_out_transmission,
   output logic      [31:0]                         rsp_start_time,
   output logic      [31:0]                         rsp_wait_time,
   output logic      [31:0]                         rsp_total_wait_out,
   output logic      [$clog2(QUEUE_DEPTH+1)-1:0]    rsp_queue_count
);
   import ppqd_pkg::*;

   localparam int AW       = $clog2(QUEUE_DEPTH);
   localparam int CW       = $clog2(QUEUE_DEPTH + 1);
   localparam int RAM_DEPTH = LEVELS << AW;
   localparam int RAW      = AW + LVL_BITS;
   localparam logic [AW-1:0] PTR_LAST = AW'(QUEUE_DEPTH - 1);
   localparam logic [CW-1:0] CNT_FULL = CW'(QUEUE_DEPTH);

   typedef enum logic [7:0] {
      S_IDLE = 8'b0000_0001,
      S_EXEC = 8'b0000_0010,
      S_LOAD = 8'b0000_0100,
      S_DIFF = 8'b0000_1000,
      S_NEG  = 8'b0001_0000,
      S_ACC  = 8'b0010_0000,
      S_ADV  = 8'b0100_0000,
      S_DONE = 8'b1000_0000
   } state_type;

   state_type state_ff, state_in;
   logic [CW-1:0]        held_ff, held_in;
   logic [CLK_BITS-1:0]  clock_ff, clock_in;
   logic [CLK_BITS-1:0]  total_ff, total_in;
   logic [CW-1:0]        lvl_cnt_ff [LEVELS];
   logic [CW-1:0]        lvl_cnt_in [LEVELS];
   logic [AW-1:0]        head_ff [LEVELS];
   logic [AW-1:0]        head_in [LEVELS];
   logic [AW-1:0]        tail_ff [LEVELS];
   logic [AW-1:0]        tail_in [LEVELS];
   logic                 rsp_valid_ff, rsp_valid_in;

   logic                 act_ff, act_in;
   logic [LVL_BITS-1:0]  lvl_ff, lvl_in;
   logic [TIME_BITS-1:0] arr_ff, arr_in;
   logic [TIME_BITS-1:0] xmt_ff, xmt_in;
   logic [CLK_BITS-1:0]  wait_ff, wait_in;
   logic [CLK_BITS-1:0]  start_ff, start_in;
   status_type           status_ff, status_in;

   status_type           rsp_status_ff, rsp_status_in;
   logic [PRIO_BITS-1:0] rsp_prio_ff, rsp_prio_in;
   logic [TIME_BITS-1:0] rsp_arr_ff, rsp_arr_in;
   logic [TIME_BITS-1:0] rsp_xmt_ff, rsp_xmt_in;
   logic [CLK_BITS-1:0]  rsp_start_ff, rsp_start_in;
   logic [CLK_BITS-1:0]  rsp_wait_ff, rsp_wait_in;
   logic [CLK_BITS-1:0]  rsp_total_ff, rsp_total_in;
   logic [CW-1:0]        rsp_count_ff, rsp_count_in;

   logic                  ram_wr_en, ram_rd_en;
   logic [RAW-1:0]        ram_wr_addr, ram_rd_addr;
   logic [ENTRY_BITS-1:0] ram_wr_data, ram_rd_data;

   alu_ctl_type          alu_ctl;
   logic [CLK_BITS-1:0]  alu_a, alu_b, alu_y;
   logic                 alu_flag;

   logic [LVL_BITS-1:0]  req_lvl;
   logic [LVL_BITS-1:0]  top_lvl;
   logic                 out_free;
   logic [CW+1:0]        lvl_sum;

   ppqd_ram #(
      .WIDTH (ENTRY_BITS),
      .DEPTH (RAM_DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   ppqd_alu u_alu (
      .ctl    (alu_ctl),
      .op_a   (alu_a),
      .op_b   (alu_b),
      .result (alu_y),
      .flag   (alu_flag)
   );

   always_comb begin
      if (req_priority_req < PRIO_MIN) begin
         req_lvl = '0;
      end else if (req_priority_req > PRIO_MAX) begin
         req_lvl = LVL_BITS'(LEVELS - 1);
      end else begin
         req_lvl = LVL_BITS'(req_priority_req - PRIO_MIN);
      end
   end

   // Highest non-empty level.
   always_comb begin
      top_lvl = '0;
      for (int i = 0; i < LEVELS; i++) begin
         if (lvl_cnt_ff[i] != '0) begin
            top_lvl = LVL_BITS'(i);
         end
      end
   end

   always_comb begin
      lvl_sum = '0;
      for (int i = 0; i < LEVELS; i++) begin
         lvl_sum = lvl_sum + {2'b00, lvl_cnt_ff[i]};
      end
   end

   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      state_in  = state_ff;
      held_in   = held_ff;
      clock_in  = clock_ff;
      total_in  = total_ff;
      lvl_cnt_in = lvl_cnt_ff;
      head_in   = head_ff;
      tail_in   = tail_ff;
      act_in    = act_ff;
      lvl_in    = lvl_ff;
      arr_in    = arr_ff;
      xmt_in    = xmt_ff;
      wait_in   = wait_ff;
      start_in  = start_ff;
      status_in = status_ff;

      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_status_in = rsp_status_ff;
      rsp_prio_in   = rsp_prio_ff;
      rsp_arr_in    = rsp_arr_ff;
      rsp_xmt_in    = rsp_xmt_ff;
      rsp_start_in  = rsp_start_ff;
      rsp_wait_in   = rsp_wait_ff;
      rsp_total_in  = rsp_total_ff;
      rsp_count_in  = rsp_count_ff;

      ram_wr_en   = 1'b0;
      ram_wr_addr = {lvl_ff, tail_ff[lvl_ff]};
      ram_wr_data = {arr_ff, xmt_ff};
      ram_rd_en   = 1'b0;
      ram_rd_addr = {top_lvl, head_ff[top_lvl]};

      alu_ctl = '{sub: 1'b0, sat: 1'b0};
      alu_a   = clock_ff;
      alu_b   = {{(CLK_BITS-TIME_BITS){1'b0}}, arr_ff};

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               act_in   = req_action;
               lvl_in   = req_lvl;
               arr_in   = req_arrival_time;
               xmt_in   = req_transmission_time;
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            state_in = S_DONE;
            if (act_ff == ACT_INSERT) begin
               if (held_ff >= CNT_FULL) begin
                  status_in = ST_FULL;
               end else begin
                  ram_wr_en           = 1'b1;
                  tail_in[lvl_ff]     = (tail_ff[lvl_ff] == PTR_LAST) ? '0
                                        : tail_ff[lvl_ff] + 1'b1;
                  lvl_cnt_in[lvl_ff]  = lvl_cnt_ff[lvl_ff] + 1'b1;
                  held_in             = held_ff + 1'b1;
                  status_in           = ST_INSERTED;
               end
            end else begin
               if (held_ff == '0) begin
                  status_in = ST_EMPTY;
               end else begin
                  ram_rd_en           = 1'b1;
                  lvl_in              = top_lvl;
                  head_in[top_lvl]    = (head_ff[top_lvl] == PTR_LAST) ? '0
                                        : head_ff[top_lvl] + 1'b1;
                  lvl_cnt_in[top_lvl] = lvl_cnt_ff[top_lvl] - 1'b1;
                  held_in             = held_ff - 1'b1;
                  status_in           = ST_DISPATCHED;
                  state_in            = S_LOAD;
               end
            end
         end
         S_LOAD: begin
            arr_in   = ram_rd_data[ENTRY_BITS-1:TIME_BITS];
            xmt_in   = ram_rd_data[TIME_BITS-1:0];
            state_in = S_DIFF;
         end
         S_DIFF: begin
            alu_ctl  = '{sub: 1'b1, sat: 1'b0};
            start_in = clock_ff;
            wait_in  = alu_y;
            state_in = alu_flag ? S_NEG : S_ACC;
         end
         S_NEG: begin
            alu_ctl  = '{sub: 1'b1, sat: 1'b0};
            alu_a    = {{(CLK_BITS-TIME_BITS){1'b0}}, arr_ff};
            alu_b    = clock_ff;
            wait_in  = alu_y;
            state_in = S_ACC;
         end
         S_ACC: begin
            alu_ctl  = '{sub: 1'b0, sat: 1'b1};
            alu_a    = total_ff;
            alu_b    = wait_ff;
            total_in = alu_y;
            state_in = S_ADV;
         end
         S_ADV: begin
            alu_ctl  = '{sub: 1'b0, sat: 1'b1};
            alu_b    = {{(CLK_BITS-TIME_BITS){1'b0}}, xmt_ff};
            clock_in = alu_y;
            state_in = S_DONE;
         end
         S_DONE: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = status_ff;
               rsp_total_in  = total_ff;
               rsp_count_in  = held_ff;
               if (status_ff == ST_DISPATCHED) begin
                  rsp_prio_in  = PRIO_BITS'(lvl_ff) + PRIO_MIN;
                  rsp_arr_in   = arr_ff;
                  rsp_xmt_in   = xmt_ff;
                  rsp_start_in = start_ff;
                  rsp_wait_in  = wait_ff;
               end else begin
                  rsp_prio_in  = '0;
                  rsp_arr_in   = '0;
                  rsp_xmt_in   = '0;
                  rsp_start_in = '0;
                  rsp_wait_in  = '0;
               end
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         held_ff      <= '0;
         clock_ff     <= '0;
         total_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < LEVELS; i++) begin
            lvl_cnt_ff[i] <= '0;
            head_ff[i]    <= '0;
            tail_ff[i]    <= '0;
         end
      end else begin
         state_ff     <= state_in;
         held_ff      <= held_in;
         clock_ff     <= clock_in;
         total_ff     <= total_in;
         rsp_valid_ff <= rsp_valid_in;
         lvl_cnt_ff   <= lvl_cnt_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
      end
   end

   always_ff @(posedge clock) begin
      act_ff        <= act_in;
      lvl_ff        <= lvl_in;
      arr_ff        <= arr_in;
      xmt_ff        <= xmt_in;
      wait_ff       <= wait_in;
      start_ff      <= start_in;
      status_ff     <= status_in;
      rsp_status_ff <= rsp_status_in;
      rsp_prio_ff   <= rsp_prio_in;
      rsp_arr_ff    <= rsp_arr_in;
      rsp_xmt_ff    <= rsp_xmt_in;
      rsp_start_ff  <= rsp_start_in;
      rsp_wait_ff   <= rsp_wait_in;
      rsp_total_ff  <= rsp_total_in;
      rsp_count_ff  <= rsp_count_in;
   end

   assign req_stall            = (state_ff != S_IDLE);
   assign rsp_valid            = rsp_valid_ff;
   assign rsp_status           = rsp_status_ff;
   assign rsp_out_priority     = rsp_prio_ff;
   assign rsp_out_arrival      = rsp_arr_ff;
   assign rsp_out_transmission = rsp_xmt_ff;
   assign rsp_start_time       = rsp_start_ff;
   assign rsp_wait_time        = rsp_wait_ff;
   assign rsp_total_wait_out   = rsp_total_ff;
   assign rsp_queue_count      = rsp_count_ff;

   `PPQD_ASSERT_SAME(a_held_bound, clock, reset, 1'b1, held_ff <= CNT_FULL,
      "held count above queue depth")
   `PPQD_ASSERT_SAME(a_level_sum, clock, reset, 1'b1, lvl_sum == {2'b00, held_ff},
      "per-level counts disagree with held count")
   `PPQD_ASSERT_NEXT(a_accept_exec, clock, reset, req_valid && !req_stall,
      state_ff == S_EXEC, "accepted request did not start execution")
   `PPQD_ASSERT_NEXT(a_done_loads, clock, reset, state_ff == S_DONE && out_free,
      rsp_valid_ff && state_ff == S_IDLE, "finished request did not load response")
   `PPQD_ASSERT_SAME(a_dispatch_prio, clock, reset,
      rsp_valid_ff && rsp_status_ff == ST_DISPATCHED,
      rsp_prio_ff >= PRIO_MIN && rsp_prio_ff <= PRIO_MAX,
      "dispatched response carries invalid priority")

endmodule
`default_nettype wire
